>>> design/avr_pkg.sv
`timescale 1ns / 1ps
package avr_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int ATAN_TAB_LEN = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CW = 34;

   localparam logic signed [CW-1:0] ROT_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] ROT_PI = 34'sd3373259426;
   localparam logic signed [CW-1:0] ROT_PI_HALF = 34'sd1686629713;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic               flip;
   } carry_type;

   typedef struct packed {
      carry_type             carry;
      logic signed [CW-1:0]  z;
   } item_type;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } sat_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] r;
      unique case (idx)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd66908022;
         5: r = 34'sd33543515;
         6: r = 34'sd16777898;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         24: r = 34'sd63;
         25: r = 34'sd31;
         26: r = 34'sd15;
         27: r = 34'sd8;
         28: r = 34'sd4;
         29: r = 34'sd2;
         30: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // product rounded half up to units of 2^-30
   function automatic logic signed [33:0] mul_rnd(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
      logic signed [65:0] pr;
      logic signed [66:0] sm;
      pr = a * b;
      sm = 67'(pr) + (67'sd1 <<< 29);
      return sm[63:30];
   endfunction

   function automatic sat_type sat32(input logic signed [36:0] v);
      sat_type r;
      if (v > 37'sd2147483647) begin
         r.ovf = 1'b1;
         r.val = 32'sh7fffffff;
      end else if (v < -37'sd2147483648) begin
         r.ovf = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.ovf = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> design/avr_front.sv
`timescale 1ns / 1ps
module avr_front import avr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_angle,
   input  logic               pop,
   output logic               q_valid,
   output item_type           q_item
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;
   logic              push;
   item_type          new_item;
   logic signed [CW-1:0] z2;

   // half angle folded into [-pi/2, pi/2]
   always_comb begin
      z2 = {{(CW-33){req_angle[31]}}, req_angle, 1'b0};
      new_item.carry.vec_x  = req_vec_x;
      new_item.carry.vec_y  = req_vec_y;
      new_item.carry.vec_z  = req_vec_z;
      new_item.carry.axis_x = req_axis_x;
      new_item.carry.axis_y = req_axis_y;
      new_item.carry.axis_z = req_axis_z;
      priority if (z2 > ROT_PI_HALF) begin
         new_item.z = z2 - ROT_PI;
         new_item.carry.flip = 1'b1;
      end else if (z2 < -ROT_PI_HALF) begin
         new_item.z = z2 + ROT_PI;
         new_item.carry.flip = 1'b1;
      end else begin
         new_item.z = z2;
         new_item.carry.flip = 1'b0;
      end
   end

   assign req_stall = (count_ff == NW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> design/avr_cordic_stage.sv
`timescale 1ns / 1ps
module avr_cordic_stage import avr_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_in,
   input  carry_type            carry_in,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [CW-1:0] z_in,
   output logic                 valid_out,
   output carry_type            carry_out,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [CW-1:0] z_out
);

   localparam logic signed [CW-1:0] ATAN = atan_q30(IDX);

   logic                 valid_ff;
   carry_type            carry_ff;
   logic signed [CW-1:0] x_ff, y_ff, z_ff, x_in_n, y_in_n, z_in_n;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      xs = x_in >>> IDX;
      ys = y_in >>> IDX;
      if (!z_in[CW-1]) begin
         x_in_n = x_in - ys;
         y_in_n = y_in + xs;
         z_in_n = z_in - ATAN;
      end else begin
         x_in_n = x_in + ys;
         y_in_n = y_in - xs;
         z_in_n = z_in + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff <= carry_in;
         x_ff     <= x_in_n;
         y_ff     <= y_in_n;
         z_ff     <= z_in_n;
      end
   end

   assign valid_out = valid_ff;
   assign carry_out = carry_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;

endmodule

>>> design/avr_back.sv
`timescale 1ns / 1ps
module avr_back import avr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_in,
   input  carry_type            carry_in,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic                 rsp_overflow
);

   logic [6:1] valid_ff;

   // half-angle cosine and sine
   logic signed [31:0] c1_ff, s1_ff;
   logic signed [31:0] ax1_ff [3];
   logic signed [31:0] v1_ff [3];
   logic signed [CW-1:0] cn, sn;

   // quaternion
   logic signed [32:0] e2_ff [4];
   logic signed [31:0] v2_ff [3];

   // pairwise products
   logic signed [33:0] p3_ff [10];
   logic signed [31:0] v3_ff [3];

   // rotation matrix
   logic signed [36:0] mr [9];
   sat_type            ms [9];
   logic signed [31:0] m4_ff [9];
   logic               ovf4_ff;
   logic signed [31:0] v4_ff [3];

   // matrix by vector terms
   logic signed [33:0] t5_ff [9];
   logic               ovf5_ff;

   sat_type            rs [3];
   logic signed [31:0] out_ff [3];
   logic               ovf6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:1], valid_in};
      end
   end

   always_comb begin
      cn = carry_in.flip ? -x_in : x_in;
      sn = carry_in.flip ? -y_in : y_in;
      mr[0] = 37'(p3_ff[0]) + 37'(p3_ff[1]) - 37'(p3_ff[2]) - 37'(p3_ff[3]);
      mr[4] = 37'(p3_ff[0]) - 37'(p3_ff[1]) + 37'(p3_ff[2]) - 37'(p3_ff[3]);
      mr[8] = 37'(p3_ff[0]) - 37'(p3_ff[1]) - 37'(p3_ff[2]) + 37'(p3_ff[3]);
      mr[1] = (37'(p3_ff[7]) - 37'(p3_ff[6])) <<< 1;
      mr[2] = (37'(p3_ff[8]) + 37'(p3_ff[5])) <<< 1;
      mr[5] = (37'(p3_ff[9]) - 37'(p3_ff[4])) <<< 1;
      mr[3] = (37'(p3_ff[7]) + 37'(p3_ff[6])) <<< 1;
      mr[6] = (37'(p3_ff[8]) - 37'(p3_ff[5])) <<< 1;
      mr[7] = (37'(p3_ff[9]) + 37'(p3_ff[4])) <<< 1;
      for (int i = 0; i < 9; i++) begin
         ms[i] = sat32(mr[i]);
      end
      for (int r = 0; r < 3; r++) begin
         rs[r] = sat32(37'(t5_ff[3*r]) + 37'(t5_ff[3*r+1]) + 37'(t5_ff[3*r+2]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff     <= cn[31:0];
         s1_ff     <= sn[31:0];
         ax1_ff[0] <= carry_in.axis_x;
         ax1_ff[1] <= carry_in.axis_y;
         ax1_ff[2] <= carry_in.axis_z;
         v1_ff[0]  <= carry_in.vec_x;
         v1_ff[1]  <= carry_in.vec_y;
         v1_ff[2]  <= carry_in.vec_z;

         e2_ff[0] <= 33'(c1_ff);
         for (int i = 0; i < 3; i++) begin
            e2_ff[i+1] <= 33'(mul_rnd(33'(ax1_ff[i]), 33'(s1_ff)));
            v2_ff[i]   <= v1_ff[i];
         end

         for (int i = 0; i < 4; i++) begin
            p3_ff[i] <= mul_rnd(e2_ff[i], e2_ff[i]);
         end
         p3_ff[4] <= mul_rnd(e2_ff[0], e2_ff[1]);
         p3_ff[5] <= mul_rnd(e2_ff[0], e2_ff[2]);
         p3_ff[6] <= mul_rnd(e2_ff[0], e2_ff[3]);
         p3_ff[7] <= mul_rnd(e2_ff[1], e2_ff[2]);
         p3_ff[8] <= mul_rnd(e2_ff[1], e2_ff[3]);
         p3_ff[9] <= mul_rnd(e2_ff[2], e2_ff[3]);
         v3_ff    <= v2_ff;

         ovf4_ff <= ms[0].ovf | ms[1].ovf | ms[2].ovf | ms[3].ovf | ms[4].ovf
                  | ms[5].ovf | ms[6].ovf | ms[7].ovf | ms[8].ovf;
         for (int i = 0; i < 9; i++) begin
            m4_ff[i] <= ms[i].val;
         end
         v4_ff <= v3_ff;

         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               t5_ff[3*r+k] <= mul_rnd(33'(m4_ff[3*r+k]), 33'(v4_ff[k]));
            end
         end
         ovf5_ff <= ovf4_ff;

         for (int r = 0; r < 3; r++) begin
            out_ff[r] <= rs[r].val;
         end
         ovf6_ff <= ovf5_ff | rs[0].ovf | rs[1].ovf | rs[2].ovf;
      end
   end

   assign rsp_valid    = valid_ff[6];
   assign rsp_out_x    = out_ff[0];
   assign rsp_out_y    = out_ff[1];
   assign rsp_out_z    = out_ff[2];
   assign rsp_overflow = ovf6_ff;

endmodule

>>> design/axis_angle_vector_rotate.sv
`timescale 1ns / 1ps
// a request word passes the queue, one register per CORDIC step and the back end
// throughput: one word per cycle while rsp_stall holds no valid result word;
// the CORDIC is unrolled one rotation per stage; a four-entry queue between the
// angle folding front and the pipeline lets the input keep flowing while the
// result side stalls, until the queue is full; reset (synchronous, active high) empties the queue and the pipeline
module axis_angle_vector_rotate import avr_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_overflow
);

   localparam int STEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;

   logic                 adv, pop, q_valid;
   item_type             q_item;
   logic                 cv [STEPS+1];
   carry_type            cc [STEPS+1];
   logic signed [CW-1:0] cx [STEPS+1];
   logic signed [CW-1:0] cy [STEPS+1];
   logic signed [CW-1:0] cz [STEPS+1];

   assign adv = !(rsp_valid && rsp_stall);
   assign pop = q_valid && adv;

   avr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .req_angle  (req_angle),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   assign cv[0] = pop;
   assign cc[0] = q_item.carry;
   assign cx[0] = ROT_GAIN;
   assign cy[0] = '0;
   assign cz[0] = q_item.z;

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      avr_cordic_stage #(.IDX(i)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .valid_in  (cv[i]),
         .carry_in  (cc[i]),
         .x_in      (cx[i]),
         .y_in      (cy[i]),
         .z_in      (cz[i]),
         .valid_out (cv[i+1]),
         .carry_out (cc[i+1]),
         .x_out     (cx[i+1]),
         .y_out     (cy[i+1]),
         .z_out     (cz[i+1])
      );
   end

   avr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .valid_in     (cv[STEPS]),
      .carry_in     (cc[STEPS]),
      .x_in         (cx[STEPS]),
      .y_in         (cy[STEPS]),
      .rsp_valid    (rsp_valid),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_overflow (rsp_overflow)
   );

endmodule

>>> design/avr_checker.sv
`timescale 1ns / 1ps
module avr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic               rsp_overflow
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_reset_ready : assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_overflow)))
      else $error("stalled result word changed");

   a_no_stall_idle : assert property (@(posedge clock) disable iff (reset)
      (!req_valid && !req_stall && !rsp_valid) |=> !req_stall)
      else $error("input stall rose with nothing accepted");

endmodule

bind axis_angle_vector_rotate avr_checker u_avr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_x    (rsp_out_x),
   .rsp_out_y    (rsp_out_y),
   .rsp_out_z    (rsp_out_z),
   .rsp_overflow (rsp_overflow)
);
